@@ rtl/gplm_pkg.sv @@
// Shared types and constants for the genotype pair locus matcher.
package gplm_pkg;

   localparam int ALLELE_W = 10;
   localparam int SCORE_W  = 2;
   localparam int COUNT_W  = 7;
   localparam int NUM_TALLY = 5;

   // Special allele codes
   localparam logic [ALLELE_W-1:0] RARE_CODE = 10'd990;
   localparam logic [ALLELE_W-1:0] WILD_CODE = 10'd0;

   // Locus score values
   localparam logic [SCORE_W-1:0] SCORE_NONE    = 2'd0;
   localparam logic [SCORE_W-1:0] SCORE_PARTIAL = 2'd1;
   localparam logic [SCORE_W-1:0] SCORE_FULL    = 2'd2;

   // Configuration register indexes
   localparam logic CSR_RARE_MODE       = 1'b0;
   localparam logic CSR_WILDCARD_EFFECT = 1'b1;

   // Tally slots in the bump vector
   localparam int TALLY_FULL     = 0;
   localparam int TALLY_PARTIAL  = 1;
   localparam int TALLY_NONE     = 2;
   localparam int TALLY_WFULL    = 3;
   localparam int TALLY_WPARTIAL = 4;

   typedef struct packed {
      logic [ALLELE_W-1:0] allele_a_first;
      logic [ALLELE_W-1:0] allele_a_second;
      logic [ALLELE_W-1:0] allele_b_first;
      logic [ALLELE_W-1:0] allele_b_second;
      logic                last_locus;
   } req_word_type;

   typedef struct packed {
      logic [SCORE_W-1:0] locus_score;
      logic [COUNT_W-1:0] full_count;
      logic [COUNT_W-1:0] partial_count;
      logic [COUNT_W-1:0] none_count;
      logic [COUNT_W-1:0] wild_full_count;
      logic [COUNT_W-1:0] wild_partial_count;
      logic               pair_done;
   } rsp_word_type;

   // Classifier verdict for one locus
   typedef struct packed {
      logic [SCORE_W-1:0]   score;
      logic [NUM_TALLY-1:0] bump;
   } match_type;

   typedef struct packed {
      logic [COUNT_W-1:0] full_count;
      logic [COUNT_W-1:0] partial_count;
      logic [COUNT_W-1:0] none_count;
      logic [COUNT_W-1:0] wild_full_count;
      logic [COUNT_W-1:0] wild_partial_count;
   } counts_type;

endpackage

@@ rtl/gplm_req_if.sv @@
// Request channel: valid/ready handshake carrying one locus word.
interface gplm_req_if;
   import gplm_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/gplm_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one result word.
interface gplm_rsp_if;
   import gplm_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/genotype_pair_locus_matcher.sv @@
// Top level of the genotype pair locus matcher: input stage, scoring, result stage.
//
//   channel  dir  handshake            word
//   req_if   in   valid/ready          four allele codes, last_locus
//   rsp_if   out  valid/ready          locus score, five tallies, pair_done
//   csr_*    in   csr_write_en only    rare_mode (index 0), wildcard_effect (index 1)
//
// One locus per cycle sustained while results are taken; a taken word goes to the input
// register, then to the result register (scoring and tally update run between the two).
// Reset clears the mode bits, the tallies and both valid flags.
// A stalled result holds the result register; the input register keeps taking a
// word as long as it empties into the result stage in the same cycle.
module genotype_pair_locus_matcher #(
   parameter int MAX_LOCI = 64
) (
   input  logic        clock,
   input  logic        reset,
   gplm_req_if.sink    req_if,
   gplm_rsp_if.source  rsp_if,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic        csr_write_data
);
   import gplm_pkg::*;

   // Configuration registers
   logic rare_mode_ff, wildcard_effect_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rare_mode_ff       <= 1'b0;
         wildcard_effect_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_RARE_MODE:       rare_mode_ff       <= csr_write_data;
            CSR_WILDCARD_EFFECT: wildcard_effect_ff <= csr_write_data;
            default:             ;
         endcase
      end
   end

   // Stage control
   logic         in_valid_ff, out_valid_ff;
   req_word_type in_word_ff;
   rsp_word_type out_word_ff, out_word_in;
   logic         advance;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) in_word_ff <= req_if.data;
   end

   // Scoring and tallies
   match_type  match;
   counts_type counts;

   gplm_classify u_classify (
      .rare_mode       (rare_mode_ff),
      .wildcard_effect (wildcard_effect_ff),
      .word            (in_word_ff),
      .match           (match)
   );

   gplm_tally #(.MAX_LOCI(MAX_LOCI)) u_tally (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .last_locus (in_word_ff.last_locus),
      .match      (match),
      .counts     (counts)
   );

   always_comb begin
      out_word_in.locus_score        = match.score;
      out_word_in.full_count         = counts.full_count;
      out_word_in.partial_count      = counts.partial_count;
      out_word_in.none_count         = counts.none_count;
      out_word_in.wild_full_count    = counts.wild_full_count;
      out_word_in.wild_partial_count = counts.wild_partial_count;
      out_word_in.pair_done          = in_word_ff.last_locus;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_word_ff <= out_word_in;
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_word_ff;

endmodule

@@ rtl/gplm_classify.sv @@
// Per-locus comparison rules: rare-allele and wildcard scoring.
module gplm_classify (
   input  logic                  rare_mode,
   input  logic                  wildcard_effect,
   input  gplm_pkg::req_word_type word,
   output gplm_pkg::match_type   match
);
   import gplm_pkg::*;

   logic [ALLELE_W-1:0] a1, a2, b1, b2;
   logic                ahom, bhom;

   assign a1   = word.allele_a_first;
   assign a2   = word.allele_a_second;
   assign b1   = word.allele_b_first;
   assign b2   = word.allele_b_second;
   assign ahom = (a1 == a2);
   assign bhom = (b1 == b2);

   // Rare-allele rules
   logic [SCORE_W-1:0] rare_s;

   always_comb begin
      logic                ar, br, a1in, a2in, rhom, ohom;
      logic [ALLELE_W-1:0] r1, r2, o1, o2;
      ar   = (a1 == RARE_CODE) || (a2 == RARE_CODE);
      br   = (b1 == RARE_CODE) || (b2 == RARE_CODE);
      a1in = (a1 == b1) || (a1 == b2);
      a2in = (a2 == b1) || (a2 == b2);
      r1   = ar ? a1 : b1;
      r2   = ar ? a2 : b2;
      o1   = ar ? b1 : a1;
      o2   = ar ? b2 : a2;
      rhom = ar ? ahom : bhom;
      ohom = ar ? bhom : ahom;
      rare_s = SCORE_NONE;
      if (!ar && !br) begin
         if (ahom && bhom)    rare_s = (a1 == b1) ? SCORE_FULL : SCORE_NONE;
         else if (ahom)       rare_s = a1in ? SCORE_PARTIAL : SCORE_NONE;
         else if (bhom)       rare_s = ((a1 == b1) || (a2 == b1)) ? SCORE_PARTIAL
                                                                  : SCORE_NONE;
         else if (a1in && a2in) rare_s = SCORE_FULL;
         else if (a1in || a2in) rare_s = SCORE_PARTIAL;
         else                 rare_s = SCORE_NONE;
      end else if (ar != br) begin
         if (rhom) begin
            rare_s = SCORE_FULL;
         end else if (r1 == RARE_CODE) begin
            if (ohom)
               rare_s = (r2 == o1) ? SCORE_PARTIAL
                      : ((r2 < o1) ? SCORE_NONE : SCORE_PARTIAL);
            else if (r2 == o1)              rare_s = SCORE_PARTIAL;
            else if (r2 == o2)              rare_s = SCORE_FULL;
            else if ((r2 < o1) && (r2 < o2)) rare_s = SCORE_NONE;
            else                            rare_s = SCORE_PARTIAL;
         end else begin
            if (ohom)
               rare_s = (r1 == o1) ? SCORE_PARTIAL
                      : ((r1 < o1) ? SCORE_PARTIAL : SCORE_NONE);
            else if (r1 == o1)              rare_s = SCORE_FULL;
            else if (r1 == o2)              rare_s = SCORE_PARTIAL;
            else if ((r1 < o1) || (r1 < o2)) rare_s = SCORE_PARTIAL;
            else                            rare_s = SCORE_NONE;
         end
      end else begin
         if (ahom || bhom) begin
            rare_s = SCORE_FULL;
         end else if (a2 == RARE_CODE) begin
            if (b2 == RARE_CODE) rare_s = (a1 == b1) ? SCORE_FULL : SCORE_PARTIAL;
            else                 rare_s = (a1 <= b2) ? SCORE_PARTIAL : SCORE_NONE;
         end else begin
            if (b2 == RARE_CODE)
               rare_s = (a2 == b1) ? SCORE_FULL
                      : ((a2 < b1) ? SCORE_NONE : SCORE_PARTIAL);
            else
               rare_s = (a2 == b2) ? SCORE_FULL : SCORE_PARTIAL;
         end
      end
   end

   // Wildcard rules: plain score, wildcard score and tally bumps
   logic [SCORE_W-1:0]   wild_sc, wild_fs;
   logic [NUM_TALLY-1:0] wild_bump;

   always_comb begin
      logic we, hit;
      we        = wildcard_effect;
      hit       = 1'b0;
      wild_sc   = SCORE_NONE;
      wild_fs   = SCORE_NONE;
      wild_bump = '0;
      if (ahom) begin
         if (a1 == WILD_CODE) begin
            wild_bump[TALLY_WFULL] = 1'b1;
            wild_fs = SCORE_FULL;
         end else if (bhom) begin
            if (b1 == WILD_CODE) begin
               wild_bump[TALLY_WFULL] = 1'b1;
            end else if (a1 == b1) begin
               wild_bump[TALLY_FULL]  = 1'b1;
               wild_sc = SCORE_FULL;
               wild_bump[TALLY_WFULL] = we;
            end else if (we) begin
               wild_bump[TALLY_WPARTIAL] = 1'b1;
               wild_sc = SCORE_PARTIAL;
            end
         end else if (b1 == WILD_CODE) begin
            if (a1 == b2) begin
               wild_bump[TALLY_WFULL] = 1'b1;
               wild_sc = SCORE_FULL;
            end else begin
               wild_bump[TALLY_WPARTIAL] = 1'b1;
               wild_sc = SCORE_PARTIAL;
            end
         end else if ((a1 == b1) || (a1 == b2)) begin
            wild_bump[TALLY_PARTIAL] = 1'b1;
            wild_sc = SCORE_PARTIAL;
            if (we) begin
               wild_bump[TALLY_WFULL] = 1'b1;
               wild_fs = SCORE_FULL;
            end
         end else if (we) begin
            wild_bump[TALLY_WPARTIAL] = 1'b1;
            wild_fs = SCORE_PARTIAL;
         end
      end else if (a1 == WILD_CODE) begin
         if (bhom)                 hit = (b1 == WILD_CODE) || (a2 == b1);
         else if (b1 == WILD_CODE) hit = (a2 == b2);
         else                      hit = (a2 == b1) || (a2 == b2);
         if (hit) begin
            wild_bump[TALLY_WFULL] = 1'b1;
            wild_fs = SCORE_FULL;
         end else begin
            wild_bump[TALLY_WPARTIAL] = 1'b1;
            wild_fs = SCORE_PARTIAL;
         end
      end else if (bhom) begin
         if (b1 == WILD_CODE) begin
            wild_bump[TALLY_WFULL] = 1'b1;
            wild_fs = SCORE_FULL;
         end else if ((a1 == b1) || (a2 == b1)) begin
            wild_bump[TALLY_PARTIAL] = 1'b1;
            wild_sc = SCORE_PARTIAL;
            if (we) begin
               wild_bump[TALLY_WFULL] = 1'b1;
               wild_fs = SCORE_FULL;
            end
         end else if (we) begin
            wild_bump[TALLY_WPARTIAL] = 1'b1;
            wild_fs = SCORE_PARTIAL;
         end
      end else if (b1 == WILD_CODE) begin
         if ((a1 == b2) || (a2 == b2)) begin
            wild_bump[TALLY_WFULL] = 1'b1;
            wild_fs = SCORE_FULL;
         end else begin
            wild_bump[TALLY_WPARTIAL] = 1'b1;
            wild_fs = SCORE_PARTIAL;
         end
      end else if ((a1 == b1) && (a2 == b2)) begin
         wild_bump[TALLY_FULL] = 1'b1;
         wild_sc = SCORE_FULL;
         if (we) begin
            wild_bump[TALLY_WFULL] = 1'b1;
            wild_fs = SCORE_FULL;
         end
      end else if (((a1 == b1) && (a2 != b2)) || ((a1 == b2) && (a2 != b1)) ||
                   ((a1 != b1) && (a2 == b2)) || ((a1 != b2) && (a2 == b1))) begin
         wild_bump[TALLY_PARTIAL] = 1'b1;
         wild_sc = SCORE_PARTIAL;
         if (we) begin
            wild_bump[TALLY_WPARTIAL] = 1'b1;
            wild_fs = SCORE_PARTIAL;
         end
      end
   end

   // Mode select; rare mode with wildcard effect reports an unset score
   always_comb begin
      match = '0;
      if (rare_mode) begin
         match.score = wildcard_effect ? SCORE_NONE : rare_s;
         match.bump[TALLY_FULL]    = (rare_s == SCORE_FULL);
         match.bump[TALLY_PARTIAL] = (rare_s == SCORE_PARTIAL);
         match.bump[TALLY_NONE]    = (rare_s != SCORE_FULL) && (rare_s != SCORE_PARTIAL);
      end else begin
         match.score = wildcard_effect ? wild_fs : wild_sc;
         match.bump  = wild_bump;
      end
   end

endmodule

@@ rtl/gplm_tally.sv @@
// Saturating per-pair tallies, cleared after the last locus of a pair.
module gplm_tally #(
   parameter int MAX_LOCI = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                last_locus,
   input  gplm_pkg::match_type match,
   output gplm_pkg::counts_type counts
);
   import gplm_pkg::*;

   localparam int LIM_W   = $clog2(MAX_LOCI + 1);
   localparam int TALLY_W = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;
   localparam logic [TALLY_W-1:0] LIMIT = TALLY_W'(MAX_LOCI);

   logic [TALLY_W-1:0] tally_ff [NUM_TALLY];
   logic [TALLY_W-1:0] tally_in [NUM_TALLY];

   // Saturating increment per tally
   always_comb begin
      for (int i = 0; i < NUM_TALLY; i++) begin
         if (match.bump[i] && (tally_ff[i] < LIMIT))
            tally_in[i] = tally_ff[i] + TALLY_W'(1);
         else
            tally_in[i] = tally_ff[i];
      end
   end

   // Updated counts go out with this locus; a pair end clears them after
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TALLY; i++) tally_ff[i] <= '0;
      end else if (advance) begin
         for (int i = 0; i < NUM_TALLY; i++)
            tally_ff[i] <= last_locus ? '0 : tally_in[i];
      end
   end

   assign counts.full_count         = tally_in[TALLY_FULL][COUNT_W-1:0];
   assign counts.partial_count      = tally_in[TALLY_PARTIAL][COUNT_W-1:0];
   assign counts.none_count         = tally_in[TALLY_NONE][COUNT_W-1:0];
   assign counts.wild_full_count    = tally_in[TALLY_WFULL][COUNT_W-1:0];
   assign counts.wild_partial_count = tally_in[TALLY_WPARTIAL][COUNT_W-1:0];

endmodule
